@@ hw/rtl/sbpd_pkg.sv @@
// Shared types, constants and helper functions of the subband pair decoder.
package sbpd_pkg;

	localparam int MAX_CODE_BITS = 8;
	localparam int VALUE_BITS    = 16;
	localparam int BAND_COUNT    = 6;
	localparam int TABLE_DEPTH   = 1 << MAX_CODE_BITS;
	localparam int SEL_W         = 3;
	localparam int ADDR_W        = SEL_W + MAX_CODE_BITS;
	localparam int RAM_DEPTH     = BAND_COUNT * TABLE_DEPTH;
	localparam int BUF_W         = MAX_CODE_BITS + 8;
	localparam int HELD_W        = $clog2(BUF_W);
	localparam int CB_W          = 4;
	localparam int CMASK_W       = MAX_CODE_BITS + 1;
	localparam int SIXCB_W       = $clog2(BAND_COUNT * MAX_CODE_BITS + 1);
	localparam int PAIR_W        = 31;
	localparam int CFG_W         = 31;
	localparam int CFG_IDX_W     = 1;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int CHAN_MAX      = 255;

	localparam logic [1:0] ACT_TABLE = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT = 1'd1;

	typedef struct packed {
		logic [1:0]         action;
		logic [2:0]         table_select;
		logic [7:0]         table_index;
		logic signed [15:0] table_value;
		logic [7:0]         coded_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
		logic       frame_end;
	} out_item_t;

	// One table operation handed from the front end to the back end.
	typedef struct packed {
		logic                         is_write;
		logic [ADDR_W-1:0]            addr;
		logic signed [VALUE_BITS-1:0] wdata;
		logic                         emit;
		logic                         last;
		logic                         frame_end;
	} op_t;

	typedef enum logic {
		FR_IDLE,
		FR_CUT
	} front_state_t;

	function automatic logic [CB_W-1:0] width_in_use(input logic [CB_W-1:0] bits);
		logic [CB_W-1:0] w;
		if (bits == '0) begin
			w = CB_W'(1);
		end else if (bits > CB_W'(MAX_CODE_BITS)) begin
			w = CB_W'(MAX_CODE_BITS);
		end else begin
			w = bits;
		end
		return w;
	endfunction

	function automatic logic signed [VALUE_BITS-1:0] narrow_value(
		input logic signed [15:0] v);
		return VALUE_BITS'(v);
	endfunction

	function automatic logic [7:0] clamp_chan(input logic signed [VALUE_BITS:0] x);
		logic [7:0] r;
		if (x < 0) begin
			r = 8'd0;
		end else if (x > CHAN_MAX) begin
			r = 8'(CHAN_MAX);
		end else begin
			r = x[7:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/sbpd_ram.sv @@
// Generic single-port RAM with registered read data.
module sbpd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ hw/rtl/sbpd_front.sv @@
// Front end: accepts items, holds configuration and cuts coded bytes into table operations.
module sbpd_front import sbpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 push,
	output op_t                  push_op,
	input  logic                 q_full
);

	front_state_t state_q, state_d;
	logic [BUF_W-1:0]  buf_q;
	logic [HELD_W-1:0] held_q;
	logic [SEL_W-1:0]  pos_q;
	logic [PAIR_W-1:0] pairs_q;
	logic [CB_W-1:0]   code_bits_q;
	logic [PAIR_W-1:0] pair_count_q;

	logic [CB_W-1:0]          cb;
	logic [MAX_CODE_BITS-1:0] cmask;
	logic [MAX_CODE_BITS-1:0] code;
	logic [HELD_W-1:0]        shamt;
	logic [HELD_W-1:0]        held_after;
	logic [SIXCB_W-1:0]       six_cb;
	logic [PAIR_W-1:0]        pairs_inc;
	logic frame_done, pos_wrap, fe, more_pair, last_px, cut_done, accept, cut_step;

	assign cb         = width_in_use(code_bits_q);
	assign cmask      = MAX_CODE_BITS'((CMASK_W'(1) << cb) - CMASK_W'(1));
	assign shamt      = held_q - HELD_W'(cb);
	assign code       = MAX_CODE_BITS'(buf_q >> shamt) & cmask;
	assign held_after = shamt;
	assign six_cb     = SIXCB_W'(BAND_COUNT) * SIXCB_W'(cb);
	assign pairs_inc  = PAIR_W'(pairs_q + 1'b1);
	assign frame_done = pairs_q >= pair_count_q;
	assign pos_wrap   = pos_q == SEL_W'(BAND_COUNT - 1);
	assign fe         = pos_wrap && (pairs_inc >= pair_count_q);
	// Another full group can only follow in the same byte when six more codes remain.
	assign more_pair  = SIXCB_W'(held_after) >= six_cb;
	assign last_px    = pos_wrap && (fe || !more_pair);
	assign cut_done   = fe || (held_after < HELD_W'(cb));
	assign in_ready   = (state_q == FR_IDLE) && !q_full;
	assign accept     = in_valid && in_ready;
	assign cut_step   = (state_q == FR_CUT) && !q_full;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE: begin
				if (accept && in_data.action == ACT_BYTE && !frame_done) begin
					state_d = FR_CUT;
				end
			end
			FR_CUT: begin
				if (!q_full && cut_done) begin
					state_d = FR_IDLE;
				end
			end
			default: state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		push    = 1'b0;
		push_op = '0;
		unique case (state_q)
			FR_IDLE: begin
				push_op.is_write = 1'b1;
				push_op.addr     = {in_data.table_select, MAX_CODE_BITS'(in_data.table_index)};
				push_op.wdata    = narrow_value(in_data.table_value);
				push = accept && in_data.action == ACT_TABLE
					&& in_data.table_select < SEL_W'(BAND_COUNT);
			end
			FR_CUT: begin
				push_op.is_write  = 1'b0;
				push_op.addr      = {pos_q, code};
				push_op.emit      = pos_wrap;
				push_op.last      = last_px;
				push_op.frame_end = fe;
				push = !q_full;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FR_IDLE;
			buf_q        <= '0;
			held_q       <= '0;
			pos_q        <= '0;
			pairs_q      <= '0;
			code_bits_q  <= CB_W'(8);
			pair_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CODE_BITS: begin
						code_bits_q <= cfg_data[CB_W-1:0];
						buf_q       <= '0;
						held_q      <= '0;
						pos_q       <= '0;
					end
					REG_PAIR_COUNT: pair_count_q <= cfg_data[PAIR_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				unique case (in_data.action)
					ACT_START: begin
						buf_q   <= '0;
						held_q  <= '0;
						pos_q   <= '0;
						pairs_q <= '0;
					end
					ACT_BYTE: begin
						if (!frame_done) begin
							buf_q  <= BUF_W'({buf_q, in_data.coded_byte});
							held_q <= held_q + HELD_W'(8);
						end
					end
					default: ;
				endcase
			end
			if (cut_step) begin
				held_q <= held_after;
				pos_q  <= pos_wrap ? '0 : pos_q + 1'b1;
				if (pos_wrap) begin
					pairs_q <= pairs_inc;
				end
				// Codes left over after the final pair of a frame are dropped.
				if (fe) begin
					buf_q  <= '0;
					held_q <= '0;
					pos_q  <= '0;
				end
			end
		end
	end

	// Between bytes the buffer never holds a whole code.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FR_IDLE |-> held_q < HELD_W'(cb))
		else $error("front end idle with a whole code still buffered");

endmodule

@@ hw/rtl/sbpd_queue.sv @@
// Short queue of table operations between the front end and the back end.
module sbpd_queue import sbpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output op_t  head_op
);

	op_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("queue underflow");

endmodule

@@ hw/rtl/sbpd_back.sv @@
// Back end: table memory access, band value collection and pixel pair output.
module sbpd_back import sbpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  op_t       head_op,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [VALUE_BITS-1:0]        rdata;
	logic signed [VALUE_BITS-1:0] decoded_q [BAND_COUNT];
	logic                         valid_s1, emit_s1, last_s1, fe_s1;
	logic [SEL_W-1:0]             pos_s1;
	out_item_t                    px0_q, px1_q;
	logic                         pair_valid_q, sel_q;
	logic signed [VALUE_BITS-1:0] lo [3];
	logic signed [VALUE_BITS-1:0] hi [3];
	logic signed [VALUE_BITS:0]   diff [3];
	logic signed [VALUE_BITS:0]   sum [3];

	// A group-closing lookup waits until the previous pair has been taken.
	assign pop = head_valid && !(head_op.emit && pair_valid_q);

	sbpd_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(RAM_DEPTH)
	) u_tables (
		.clk  (clk),
		.we   (pop && head_op.is_write),
		.addr (head_op.addr),
		.wdata(head_op.wdata),
		.rdata(rdata)
	);

	always_comb begin
		lo[0] = decoded_q[0];
		hi[0] = decoded_q[1];
		lo[1] = decoded_q[2];
		hi[1] = decoded_q[3];
		lo[2] = decoded_q[4];
		hi[2] = signed'(rdata);
		for (int c = 0; c < 3; c++) begin
			diff[c] = (VALUE_BITS+1)'(lo[c]) - (VALUE_BITS+1)'(hi[c]);
			sum[c]  = (VALUE_BITS+1)'(lo[c]) + (VALUE_BITS+1)'(hi[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			emit_s1 <= head_op.emit;
			last_s1 <= head_op.last;
			fe_s1   <= head_op.frame_end;
			pos_s1  <= head_op.addr[ADDR_W-1 -: SEL_W];
		end
		if (valid_s1) begin
			decoded_q[pos_s1] <= signed'(rdata);
		end
		if (valid_s1 && emit_s1) begin
			px0_q.red       <= clamp_chan(diff[0]);
			px0_q.green     <= clamp_chan(diff[1]);
			px0_q.blue      <= clamp_chan(diff[2]);
			px0_q.last      <= 1'b0;
			px0_q.frame_end <= 1'b0;
			px1_q.red       <= clamp_chan(sum[0]);
			px1_q.green     <= clamp_chan(sum[1]);
			px1_q.blue      <= clamp_chan(sum[2]);
			px1_q.last      <= last_s1;
			px1_q.frame_end <= fe_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			pair_valid_q <= 1'b0;
			sel_q        <= 1'b0;
		end else begin
			valid_s1 <= pop && !head_op.is_write;
			if (valid_s1 && emit_s1) begin
				pair_valid_q <= 1'b1;
				sel_q        <= 1'b0;
			end else if (out_valid && out_ready) begin
				if (sel_q) begin
					pair_valid_q <= 1'b0;
					sel_q        <= 1'b0;
				end else begin
					sel_q <= 1'b1;
				end
			end
		end
	end

	assign out_valid = pair_valid_q;
	assign out_data  = sel_q ? px1_q : px0_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && emit_s1 |-> !pair_valid_q)
		else $error("new pixel pair would overwrite one not yet transferred");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && sel_q |=> !pair_valid_q || !sel_q)
		else $error("second pixel of a pair repeated");

endmodule

@@ hw/rtl/subband_pair_dequant_decoder.sv @@
// Top level of the two-band sum/difference subband pair decoder.
// Table-write items fill six dequantization tables (low and high band of red, green and
// blue). A coded byte is cut MSB first into codes of code_bits bits (a code_bits of 0
// counts as 1, one above 8 as 8), one code per cycle while the queue has room, each code
// one read of the single-port table memory; every sixth code closes a group that yields
// two pixels, low minus high and then low plus high, clamped to 0..255, each taking one
// output transfer. A short queue lets the byte cutter run ahead while pixels wait on the
// output. Bytes after the frame's last pair are dropped until a start item; configuration
// is to be written only while the block is idle, which the block itself does not enforce,
// and a code_bits write discards any partly held code.
module subband_pair_dequant_decoder import sbpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic push, q_full, pop, head_valid;
	op_t  push_op, head_op;

	sbpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.push_op  (push_op),
		.q_full   (q_full)
	);

	sbpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_op   (head_op)
	);

	sbpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_op   (head_op),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ tb/subband_pair_dequant_decoder_tb.sv @@
// Self-checking testbench for the subband pair decoder: table fill, code cutting and pixel output.
`timescale 1ns / 1ps

module subband_pair_dequant_decoder_tb;
	import sbpd_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int TBL_N = BAND_COUNT * TABLE_DEPTH;
	localparam int ITEM_TARGET = 450;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;
	localparam int PLAN_N = 11;
	localparam logic [3:0] WIDTH_PLAN [PLAN_N] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd15, 4'd9,
		4'd4, 4'd5, 4'd6, 4'd7, 4'd8};

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// Two copies of the decoder state: copy 0 runs ahead as items are queued, copy 1
	// follows the items the block actually accepts.
	logic signed [15:0] band_val [2][TBL_N];
	bit band_set [2][TBL_N];
	logic [23:0] stream_bits [2];
	int unsigned bits_held [2];
	int unsigned group_pos [2];
	logic signed [15:0] band_code_val [2][BAND_COUNT];
	logic [30:0] pairs_made [2];
	logic [3:0] code_width [2];
	logic [30:0] pair_limit [2];
	out_item_t pixel_out [2][4];
	int unfilled [$];

	in_item_t pending_items [$];
	out_item_t expected_pixels [$];
	bit no_idle = 1'b0;
	int hold_reqs = 0;
	int hold_taken;
	int tx_wait;
	int rx_stall;
	int bad_count = 0;
	int items_in = 0;
	int pixels_seen = 0;
	int quiet = 0;
	int fed = 0;

	subband_pair_dequant_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Runs one item through copy s and returns the number of pixels it yields. With probe
	// set, the state is left untouched and only the reads of unwritten table entries are recorded.
	function automatic int dequant_step(input int s, input in_item_t it, input bit probe);
		logic [23:0] sb;
		int unsigned held, pos, w, code, addr;
		logic [30:0] done;
		logic signed [15:0] vals [BAND_COUNT];
		logic [7:0] ch [3];
		int lo, hi, x, n;
		n = 0;
		sb = stream_bits[s];
		held = bits_held[s];
		pos = group_pos[s];
		done = pairs_made[s];
		for (int i = 0; i < BAND_COUNT; i++) vals[i] = band_code_val[s][i];
		case (it.action)
		ACT_TABLE: begin
			if (it.table_select < BAND_COUNT && !probe) begin
				addr = it.table_select * TABLE_DEPTH + it.table_index;
				band_val[s][addr] = it.table_value;
				band_set[s][addr] = 1'b1;
			end
		end
		ACT_START: begin
			sb = '0;
			held = 0;
			pos = 0;
			done = '0;
			for (int i = 0; i < BAND_COUNT; i++) vals[i] = '0;
		end
		ACT_BYTE: begin
			if (done < pair_limit[s]) begin
				w = code_width[s] == 0 ? 1 :
					(code_width[s] > MAX_CODE_BITS ? MAX_CODE_BITS : code_width[s]);
				sb = {sb[15:0], it.coded_byte};
				held += 8;
				while (held >= w && done < pair_limit[s]) begin
					code = (32'(sb) >> (held - w)) & ((32'd1 << w) - 1);
					pos = pos % BAND_COUNT;
					held -= w;
					addr = pos * TABLE_DEPTH + code;
					if (!band_set[s][addr]) unfilled.push_back(addr);
					vals[pos] = band_val[s][addr];
					pos++;
					if (pos == BAND_COUNT) begin
						pos = 0;
						if (n + 2 > 4) break;
						// First pixel of a pair is low minus high, the second low plus high.
						for (int k = 0; k < 2; k++) begin
							for (int c = 0; c < 3; c++) begin
								lo = vals[2 * c];
								hi = vals[2 * c + 1];
								x = k ? lo + hi : lo - hi;
								ch[c] = x < 0 ? 8'd0 : (x > CHAN_MAX ? 8'(CHAN_MAX) : 8'(x));
							end
							pixel_out[s][n + k].red = ch[0];
							pixel_out[s][n + k].green = ch[1];
							pixel_out[s][n + k].blue = ch[2];
							pixel_out[s][n + k].last = 1'b0;
							pixel_out[s][n + k].frame_end = 1'b0;
						end
						done++;
						if (done >= pair_limit[s]) pixel_out[s][n + 1].frame_end = 1'b1;
						n += 2;
					end
				end
				sb = held == 0 ? 24'd0 : sb & ((24'd1 << held) - 24'd1);
				// Codes left over after the frame's final pair are thrown away.
				if (done >= pair_limit[s]) begin
					sb = '0;
					held = 0;
					pos = 0;
				end
			end
		end
		default: ;
		endcase
		if (n > 0) pixel_out[s][n - 1].last = 1'b1;
		if (!probe) begin
			stream_bits[s] = sb;
			bits_held[s] = held;
			group_pos[s] = pos;
			pairs_made[s] = done;
			for (int i = 0; i < BAND_COUNT; i++) band_code_val[s][i] = vals[i];
		end
		return n;
	endfunction

	function automatic logic [15:0] rand_value();
		logic [15:0] v;
		case ($urandom_range(0, 3))
		0: v = 16'($urandom);
		1: v = 16'($urandom_range(0, 255));
		2: v = 16'($urandom_range(0, 383)) - 16'd64;
		default: v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
		endcase
		return v;
	endfunction

	function automatic in_item_t noise_item(input logic [1:0] act);
		in_item_t it;
		it.action = act;
		it.table_select = 3'($urandom);
		it.table_index = 8'($urandom);
		it.table_value = 16'($urandom);
		it.coded_byte = 8'($urandom);
		return it;
	endfunction

	task automatic put_item(input in_item_t it);
		if ((it.action == ACT_TABLE && it.table_select < BAND_COUNT) || it.action == ACT_START ||
				(it.action == ACT_BYTE && pairs_made[0] < pair_limit[0])) begin
			fed++;
		end
		void'(dequant_step(0, it, 1'b0));
		pending_items.push_back(it);
	endtask

	task automatic put_entry(input int sel, input int idx, input logic [15:0] val);
		in_item_t it;
		it = noise_item(ACT_TABLE);
		it.table_select = 3'(sel);
		it.table_index = 8'(idx);
		it.table_value = val;
		put_item(it);
	endtask

	// Any table entry the byte is about to read gets written first.
	task automatic put_byte(input logic [7:0] b);
		in_item_t it;
		it = noise_item(ACT_BYTE);
		it.coded_byte = b;
		unfilled.delete();
		void'(dequant_step(0, it, 1'b1));
		foreach (unfilled[i]) begin
			if (!band_set[0][unfilled[i]]) begin
				put_entry(unfilled[i] / TABLE_DEPTH, unfilled[i] % TABLE_DEPTH, rand_value());
			end
		end
		put_item(it);
	endtask

	task automatic drain(input int extra);
		while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0) begin
			@(negedge clk);
		end
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		for (int s = 0; s < 2; s++) begin
			if (idx == REG_CODE_BITS) begin
				code_width[s] = val[3:0];
				stream_bits[s] = '0;
				bits_held[s] = 0;
				group_pos[s] = 0;
			end else begin
				pair_limit[s] = val;
			end
		end
		@(negedge clk);
	endtask

	// Input side: offers queued items and updates the checking copy on each transfer.
	always @(posedge clk or negedge arst_n) begin : feed
		int n;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			tx_wait <= 0;
		end else begin
			if (in_valid && in_ready) begin
				n = dequant_step(1, in_data, 1'b0);
				for (int k = 0; k < n; k++) expected_pixels.push_back(pixel_out[1][k]);
				items_in++;
			end
			if (!in_valid || in_ready) begin
				if (tx_wait != 0) begin
					in_valid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (pending_items.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
					tx_wait <= no_idle ? 0 : $urandom_range(0, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: checks each pixel transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : sink
		out_item_t want;
		int d;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall <= 0;
			hold_taken <= 0;
		end else begin
			if (out_valid && out_ready) begin
				pixels_seen++;
				if (expected_pixels.size() == 0) begin
					bad_count++;
					if (bad_count <= REPORT_LIMIT) begin
						$display("unexpected pixel r=%0d g=%0d b=%0d last=%0b frame_end=%0b",
							out_data.red, out_data.green, out_data.blue, out_data.last,
							out_data.frame_end);
					end
				end else begin
					want = expected_pixels.pop_front();
					if (out_data.red !== want.red || out_data.green !== want.green ||
							out_data.blue !== want.blue || out_data.last !== want.last ||
							out_data.frame_end !== want.frame_end) begin
						bad_count++;
						if (bad_count <= REPORT_LIMIT) begin
							$display("pixel %0d: expected r=%0d g=%0d b=%0d last=%0b end=%0b, got r=%0d g=%0d b=%0d last=%0b end=%0b",
								pixels_seen, want.red, want.green, want.blue, want.last,
								want.frame_end, out_data.red, out_data.green, out_data.blue,
								out_data.last, out_data.frame_end);
						end
					end
				end
			end
			if (hold_taken != hold_reqs) begin
				hold_taken <= hold_reqs;
				out_ready <= 1'b0;
				rx_stall <= LONG_HOLD;
			end else if (out_valid && out_ready) begin
				d = no_idle ? 0 : $urandom_range(0, 3);
				out_ready <= d == 0;
				rx_stall <= d == 0 ? 0 : d - 1;
			end else if (rx_stall != 0) begin
				out_ready <= 1'b0;
				rx_stall <= rx_stall - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("no transfer for %0d cycles, %0d items queued, %0d pixels still due",
				quiet, pending_items.size(), expected_pixels.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic [3:0] width;
		logic [30:0] limit;
		int phase_no, nitems, r;
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < TBL_N; i++) begin
				band_val[s][i] = '0;
				band_set[s][i] = 1'b0;
			end
			for (int i = 0; i < BAND_COUNT; i++) band_code_val[s][i] = '0;
			stream_bits[s] = '0;
			bits_held[s] = 0;
			group_pos[s] = 0;
			pairs_made[s] = '0;
			code_width[s] = 4'd8;
			pair_limit[s] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// With a pair count of zero a byte is dropped; the other three are ignored anyway.
		put_byte(8'hA5);
		put_item(noise_item(ACT_NONE));
		put_entry(6, 8'h5A, rand_value());
		put_entry(7, 8'hC3, rand_value());
		drain(SETTLE_CYCLES);
		write_reg(REG_PAIR_COUNT, 31'd2);
		// Code 0 gives a saturated difference, code 255 a saturated sum.
		for (int sel = 0; sel < BAND_COUNT; sel++) begin
			put_entry(sel, 0, sel % 2 == 0 ? 16'h7fff : 16'h8000);
			put_entry(sel, 255, 16'h7fff);
		end
		repeat (6) put_byte(8'h00);
		repeat (6) put_byte(8'hFF);
		put_byte(8'h3C);
		put_item(noise_item(ACT_START));

		phase_no = 0;
		while (fed < ITEM_TARGET) begin
			drain(SETTLE_CYCLES);
			width = phase_no < PLAN_N ? WIDTH_PLAN[phase_no] : 4'($urandom_range(0, 15));
			if (phase_no == 2) begin
				limit = 31'h7fffffff;
			end else if (phase_no == 4) begin
				// Drop the pair count below the pairs already decoded, or to zero if none were.
				limit = pairs_made[0] > 0 ? 31'($urandom_range(0, pairs_made[0] - 1)) : '0;
			end else if ($urandom_range(0, 9) == 0) begin
				limit = '0;
			end else begin
				limit = 31'($urandom_range(1, 30));
			end
			write_reg(REG_CODE_BITS, 31'(width));
			write_reg(REG_PAIR_COUNT, limit);
			no_idle = phase_no % 3 == 1;
			if (phase_no != 4 && $urandom_range(0, 2) != 0) put_item(noise_item(ACT_START));
			nitems = $urandom_range(15, 50);
			for (int i = 0; i < nitems; i++) begin
				if (phase_no == 3 && i == nitems / 2) drain(0);
				r = $urandom_range(0, 99);
				if (pairs_made[0] >= pair_limit[0] && r < 50) begin
					put_item(noise_item(ACT_START));
				end else if (r < 80) begin
					put_byte(8'($urandom));
				end else if (r < 90) begin
					put_entry($urandom_range(0, 7), $urandom_range(0, 255), rand_value());
				end else if (r < 95) begin
					put_item(noise_item(ACT_START));
				end else begin
					put_item(noise_item(ACT_NONE));
				end
			end
			// Hold the output back while the whole phase is still queued at the input.
			if (phase_no == 2) hold_reqs++;
			phase_no++;
		end

		drain(SETTLE_CYCLES);
		$display("Run covered %0d accepted items and %0d checked pixels over %0d phases.",
			items_in, pixels_seen, phase_no);
		$display("Code widths 0 to 15, pair counts from 0 to the maximum, %0d mismatches.",
			bad_count);
		if (bad_count == 0 && expected_pixels.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
